@@ sv/board_overlay_pixel_generator_core_defines.svh @@
// Assertion macros shared by the board overlay pixel generator RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef BOARD_OVERLAY_PIXEL_GENERATOR_CORE_DEFINES_SVH
`define BOARD_OVERLAY_PIXEL_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BOPG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BOPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bopg_pkg.sv @@
// Shared types and constants for the board overlay pixel generator.
// No dependencies; used by bopg_tables and the top level.
package bopg_pkg;

    localparam int CELL_PITCH_DEF  = 14;
    localparam int BOARD_CELLS_DEF = 256;

    // Request kinds carried on the input tuser
    typedef enum logic [2:0] {
        OP_COL_WR   = 3'd0,
        OP_ROW_WR   = 3'd1,
        OP_SHAPE_WR = 3'd2,
        OP_BOARD_WR = 3'd3,
        OP_PIXEL    = 3'd4
    } op_t;

    // Table write strobe bundle from the front end to the table block
    typedef struct packed {
        logic       col_we;
        logic       row_we;
        logic       shape_we;
        logic       board_we;
        logic [7:0] addr;
        logic [3:0] data;
    } tbl_wr_t;

endpackage

@@ sv/board_overlay_pixel_generator_core.sv @@
// Board overlay pixel generator: request decode, cell math, color pipeline.
// Depends on bopg_pkg, bopg_tables and the assertion macro header.
//
// Usage:
//   Input stream s_axis_*: tuser carries the request kind (column, row or
//   shape table write, board RAM write, pixel); tdata carries address,
//   write data and the pixel source position. Table writes take effect the
//   cycle they are accepted and give no output.
//   Output stream m_axis_*: one request per pixel with the palette index and
//   the destination screen position.
//   cfg_we/cfg_wdata set the display enable; write it only while idle.
// Pipeline: the column and row tables are read as a pixel is accepted, then
//   the shape table and board RAM are read, and then the color select is
//   registered into the output register.
// Throughput: one request per cycle while m_axis is not stalled, set by the
//   synchronous reads of the table RAMs that form the pipeline stages.
// Reset: board cells read as zero (per-cell valid bits), display off, the
//   pipeline empties. Shape tables hold garbage until written.
// Stall: while m_axis holds an untaken pixel, the whole pipeline freezes and
//   s_axis_tready drops; it rises again in the cycle the output is taken.
`include "board_overlay_pixel_generator_core_defines.svh"

module board_overlay_pixel_generator_core #(
    parameter int CELL_PITCH  = bopg_pkg::CELL_PITCH_DEF,
    parameter int BOARD_CELLS = bopg_pkg::BOARD_CELLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address, write_data, pixel_x, pixel_y
    input  logic [2:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // color_index, screen_x, screen_y
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    localparam int DIV_RECIP = (65536 + CELL_PITCH - 1) / CELL_PITCH;
    localparam logic [7:0] ORIGIN_X = 8'd253;
    localparam logic [7:0] ORIGIN_Y = 8'd245;
    localparam logic [8:0] SCREEN_X_OFS = 9'd262;
    localparam logic [8:0] SCREEN_Y_OFS = 9'd254;
    localparam logic [5:0] COL_BLACK  = 6'h20;
    localparam logic [5:0] COL_BOARD  = 6'h21;
    localparam logic [5:0] COL_WHITE  = 6'h22;
    localparam logic [5:0] COL_BRIGHT = 6'h2f;

    bopg_pkg::op_t     op;
    bopg_pkg::tbl_wr_t wr;
    logic [7:0] address;
    logic [7:0] write_data;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;

    logic adv;
    logic acc;

    logic       en_reg;
    logic       p1_v_reg, p1_v_next;
    logic       p2_v_reg, p2_v_next;
    logic       out_v_reg, out_v_next;
    logic [7:0] p1_cell_reg;
    logic [8:0] p1_sx_reg, p1_sy_reg;
    logic [8:0] p2_sx_reg, p2_sy_reg;
    logic [5:0] out_color_reg, out_color_next;
    logic [8:0] out_sx_reg, out_sy_reg;

    logic [7:0] dx, dy, qx, qy, cell_idx;
    logic [7:0] shape_addr;
    logic [3:0] col_q, row_q, shape_q, board_q;
    logic       color_ok;

    function automatic logic [7:0] pitch_div(input logic [7:0] d);
        logic [24:0] prod;
        prod = 25'(d) * 25'(DIV_RECIP);
        return prod[23:16];
    endfunction

    function automatic logic [5:0] pixel_color(input logic en, input logic [3:0] shape,
                                               input logic [3:0] cell_bits);
        logic [5:0] c;
        c = COL_BLACK;
        if (shape[0])
            c = COL_BOARD;
        if (shape[1])
            c = COL_BLACK;
        if (shape[2])
        begin
            if (cell_bits[0])
                c = COL_BRIGHT;
            else if (cell_bits[1])
                c = COL_WHITE;
        end
        if (shape[3])
        begin
            if (cell_bits[2])
                c = COL_BRIGHT;
            else if (cell_bits[3])
                c = COL_WHITE;
        end
        if (!en)
            c = COL_BLACK;
        return c;
    endfunction

    assign op         = bopg_pkg::op_t'(s_axis_tuser);
    assign address    = s_axis_tdata[7:0];
    assign write_data = s_axis_tdata[15:8];
    assign pixel_x    = s_axis_tdata[23:16];
    assign pixel_y    = s_axis_tdata[31:24];

    assign adv           = !out_v_reg || m_axis_tready;
    assign acc           = s_axis_tvalid && adv;
    assign s_axis_tready = adv;

    always_comb
    begin
        wr          = '0;
        wr.addr     = address;
        wr.data     = write_data[3:0];
        if (acc)
        begin
            case (op)
                bopg_pkg::OP_COL_WR:   wr.col_we   = 1'b1;
                bopg_pkg::OP_ROW_WR:   wr.row_we   = 1'b1;
                bopg_pkg::OP_SHAPE_WR: wr.shape_we = 1'b1;
                bopg_pkg::OP_BOARD_WR: wr.board_we = 1'b1;
                default:               wr.addr     = address;
            endcase
        end
    end

    // Board cell under the pixel; coordinates at or past the origin clamp to 0
    assign dx = (pixel_x >= ORIGIN_X) ? 8'd0 : 8'(ORIGIN_X - pixel_x);
    assign dy = (pixel_y >= ORIGIN_Y) ? 8'd0 : 8'(ORIGIN_Y - pixel_y);
    assign qx = pitch_div(dx);
    assign qy = pitch_div(dy);
    assign cell_idx = qx | {qy[3:0], 4'h0};

    assign shape_addr = {4'h0, col_q} + {row_q, 4'h0};

    bopg_tables #(
        .BOARD_CELLS(BOARD_CELLS)
    ) u_tables (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd_en     (adv),
        .col_addr  (pixel_x),
        .row_addr  (pixel_y),
        .shape_addr(shape_addr),
        .board_addr(p1_cell_reg),
        .col_q     (col_q),
        .row_q     (row_q),
        .shape_q   (shape_q),
        .board_q   (board_q)
    );

    always_comb
    begin
        p1_v_next      = p1_v_reg;
        p2_v_next      = p2_v_reg;
        out_v_next     = out_v_reg;
        out_color_next = pixel_color(en_reg, shape_q, board_q);
        if (adv)
        begin
            p1_v_next  = acc && (op == bopg_pkg::OP_PIXEL);
            p2_v_next  = p1_v_reg;
            out_v_next = p2_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                en_reg <= cfg_wdata;
            p1_v_reg  <= p1_v_next;
            p2_v_reg  <= p2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_cell_reg   <= cell_idx;
            p1_sx_reg     <= SCREEN_X_OFS - {1'b0, pixel_x};
            p1_sy_reg     <= SCREEN_Y_OFS - {1'b0, pixel_y};
            p2_sx_reg     <= p1_sx_reg;
            p2_sy_reg     <= p1_sy_reg;
            out_color_reg <= out_color_next;
            out_sx_reg    <= p2_sx_reg;
            out_sy_reg    <= p2_sy_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {out_sy_reg, out_sx_reg, out_color_reg};

    assign color_ok = (m_axis_tdata[5:0] == COL_BLACK) || (m_axis_tdata[5:0] == COL_BOARD) ||
                      (m_axis_tdata[5:0] == COL_WHITE) || (m_axis_tdata[5:0] == COL_BRIGHT);

    `BOPG_ASSERT_NOW(a_color_legal, m_axis_tvalid, color_ok, "illegal color index")
    `BOPG_ASSERT_NEXT(a_display_off, adv && p2_v_reg && !en_reg, m_axis_tdata[5:0] == COL_BLACK, "display off but color not black")
    `BOPG_ASSERT_NEXT(a_no_result_for_write, acc && (op != bopg_pkg::OP_PIXEL), !p1_v_reg, "write request entered pixel pipe")
    `BOPG_ASSERT_NEXT(a_freeze_on_stall, !adv, $stable(p1_v_reg) && $stable(p2_v_reg), "pipeline moved while stalled")

endmodule

@@ sv/bopg_tables.sv @@
// Shape tables and board RAM of the board overlay pixel generator.
// Depends on bopg_pkg (tbl_wr_t). Reads are registered.
module bopg_tables #(
    parameter int BOARD_CELLS = bopg_pkg::BOARD_CELLS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bopg_pkg::tbl_wr_t wr,
    input  logic              rd_en,
    input  logic [7:0]        col_addr,
    input  logic [7:0]        row_addr,
    input  logic [7:0]        shape_addr,
    input  logic [7:0]        board_addr,
    output logic [3:0]        col_q,
    output logic [3:0]        row_q,
    output logic [3:0]        shape_q,
    output logic [3:0]        board_q
);

    localparam int CELL_AW   = $clog2(BOARD_CELLS);
    localparam int MOD_RECIP = (65536 + BOARD_CELLS - 1) / BOARD_CELLS;

    logic [3:0] col_mem   [256];
    logic [3:0] row_mem   [256];
    logic [3:0] shape_mem [256];
    logic [3:0] board_mem [BOARD_CELLS];

    logic [BOARD_CELLS-1:0] vld_reg;
    logic                   board_hit_reg;
    logic [3:0]             col_q_reg;
    logic [3:0]             row_q_reg;
    logic [3:0]             shape_q_reg;
    logic [3:0]             board_rd_reg;

    logic [CELL_AW-1:0] brd_wr_idx;
    logic [CELL_AW-1:0] brd_rd_idx;

    // v mod BOARD_CELLS by reciprocal; exact for 8-bit v
    function automatic logic [CELL_AW-1:0] cell_mod(input logic [7:0] v);
        logic [24:0] prod;
        logic [7:0]  q;
        logic [15:0] r;
        prod = 25'(v) * 25'(MOD_RECIP);
        q    = prod[23:16];
        r    = 16'(v) - 16'(q) * 16'(BOARD_CELLS);
        return r[CELL_AW-1:0];
    endfunction

    assign brd_wr_idx = cell_mod(wr.addr);
    assign brd_rd_idx = cell_mod(board_addr);

    // Read-before-write: a later write never leaks into an earlier read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            col_q_reg    <= col_mem[col_addr];
            row_q_reg    <= row_mem[row_addr];
            shape_q_reg  <= shape_mem[shape_addr];
            board_rd_reg <= board_mem[brd_rd_idx];
        end
        if (wr.col_we)
            col_mem[wr.addr] <= wr.data;
        if (wr.row_we)
            row_mem[wr.addr] <= wr.data;
        if (wr.shape_we)
            shape_mem[wr.addr] <= wr.data;
        if (wr.board_we)
            board_mem[brd_wr_idx] <= wr.data;
    end

    // Per-cell valid bits stand in for the zeroed board after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            board_hit_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
                board_hit_reg <= vld_reg[brd_rd_idx];
            if (wr.board_we)
                vld_reg[brd_wr_idx] <= 1'b1;
        end
    end

    assign col_q   = col_q_reg;
    assign row_q   = row_q_reg;
    assign shape_q = shape_q_reg;
    assign board_q = board_hit_reg ? board_rd_reg : 4'h0;

endmodule
